[rtl/core/frp_pkg.sv]
// ----------------------------------------------------------------------------
// Framed reply parser package
// Phase codes, event codes and frame constants that the parser and its
// channel interfaces share.
// ----------------------------------------------------------------------------
package frp_pkg;

   // Widths of the channel fields.
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned OP_W     = 1;
   localparam int unsigned EVENT_W  = 3;
   localparam int unsigned LENGTH_W = 16;
   localparam int unsigned PHASE_W  = 4;
   localparam int unsigned CSR_IDX_W = 1;

   typedef logic [BYTE_W-1:0]    byte_type;
   typedef logic [OP_W-1:0]      op_type;
   typedef logic [EVENT_W-1:0]   event_type;
   typedef logic [LENGTH_W-1:0]  length_type;
   typedef logic [PHASE_W-1:0]   phase_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // Input operations.
   localparam op_type OP_BYTE   = 1'b0;
   localparam op_type OP_RESYNC = 1'b1;

   // Parser phases.
   localparam phase_type PH_WAIT = 4'd0;
   localparam phase_type PH_HEAD = 4'd1;
   localparam phase_type PH_CON  = 4'd2;
   localparam phase_type PH_CMD  = 4'd3;
   localparam phase_type PH_LENH = 4'd4;
   localparam phase_type PH_LENL = 4'd5;
   localparam phase_type PH_DATA = 4'd6;
   localparam phase_type PH_CHK  = 4'd7;
   localparam phase_type PH_ENDH = 4'd8;
   localparam phase_type PH_ENDL = 4'd9;

   // Result events.
   localparam event_type EV_NONE = 3'd0;
   localparam event_type EV_BYTE = 3'd1;
   localparam event_type EV_GOOD = 3'd2;
   localparam event_type EV_CSUM = 3'd3;
   localparam event_type EV_FOOT = 3'd4;

   // Configuration register indexes.
   localparam csr_idx_type CSR_CONTROL = 1'b0;
   localparam csr_idx_type CSR_COMMAND = 1'b1;

   // Frame delimiters.
   localparam byte_type HEADER_0 = 8'h53;
   localparam byte_type HEADER_1 = 8'h59;
   localparam byte_type FOOTER_0 = 8'h54;
   localparam byte_type FOOTER_1 = 8'h43;

endpackage

[rtl/core/frp_req_if.sv]
// ----------------------------------------------------------------------------
// Framed reply parser request channel
// Carries one received byte or a resync operation per transfer.
// ----------------------------------------------------------------------------
interface frp_req_if;
   logic              valid;
   logic              ready;
   frp_pkg::op_type   op;
   frp_pkg::byte_type rx_byte;

   modport source (output valid, output op, output rx_byte, input ready);
   modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

[rtl/core/frp_rsp_if.sv]
// ----------------------------------------------------------------------------
// Framed reply parser response channel
// Carries one parse event per transfer.
// ----------------------------------------------------------------------------
interface frp_rsp_if;
   logic                valid;
   logic                ready;
   frp_pkg::event_type  event_res;
   frp_pkg::byte_type   payload_byte;
   frp_pkg::length_type payload_index;
   frp_pkg::length_type payload_length;

   modport source (output valid, output event_res, output payload_byte,
                   output payload_index, output payload_length, input ready);
   modport sink   (input valid, input event_res, input payload_byte,
                   input payload_index, input payload_length, output ready);
endinterface

[rtl/core/frp_csr_if.sv]
// ----------------------------------------------------------------------------
// Framed reply parser register write channel
// Carries one register index and its write data per transfer.
// ----------------------------------------------------------------------------
interface frp_csr_if;
   logic                 valid;
   logic                 ready;
   frp_pkg::csr_idx_type index;
   frp_pkg::byte_type    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/framed_reply_parser_core.sv]
// ----------------------------------------------------------------------------
// Framed reply parser core
// Byte-serial receiver that finds reply frames, streams their payload bytes
// and reports good frames, checksum mismatches and footer mismatches.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Carries
//   -------  ---------  ------------------------------------------------
//   req_ch   in         op, rx_byte: one received byte or a resync
//   rsp_ch   out        event_res, payload_byte, payload_index, length
//   csr_ch   in         index, data: expected control / command bytes
//
// Every request transfer produces exactly one response, registered in the cycle after the transfer.
// The parser state and the response register update in the same cycle, so
// a byte can be taken every cycle while rsp ready is high (one byte per cycle sustained).
// A stalled response holds in its register; a new request is taken only
// when that register is empty or being drained in the same cycle.
// Reset is synchronous and clears the parser, the configuration registers and rsp valid.
// Register writes are always taken.
//
module framed_reply_parser_core (
   input logic    clock,
   input logic    reset,
   frp_req_if.sink   req_ch,
   frp_rsp_if.source rsp_ch,
   frp_csr_if.sink   csr_ch
);

   // Configuration registers.
   frp_pkg::byte_type   expected_control_ff;
   frp_pkg::byte_type   expected_command_ff;

   // Parser state.
   frp_pkg::phase_type  phase_ff, phase_in;
   frp_pkg::length_type frame_length_ff, frame_length_in;
   frp_pkg::length_type collected_ff, collected_in;
   frp_pkg::byte_type   sum_ff, sum_in;

   // Response register.
   logic                rsp_valid_ff;
   frp_pkg::event_type  event_ff, event_in;
   frp_pkg::byte_type   pbyte_ff, pbyte_in;
   frp_pkg::length_type pidx_ff, pidx_in;
   frp_pkg::length_type plen_ff, plen_in;

   logic                req_xfer;
   frp_pkg::byte_type   rx;
   frp_pkg::byte_type   sum_next;
   frp_pkg::length_type length_full;
   frp_pkg::length_type collected_inc;

   // Take a request when the response register is free or drains now.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rx            = req_ch.rx_byte;
   assign sum_next      = sum_ff + rx;
   assign length_full   = {frame_length_ff[15:8], rx};
   assign collected_inc = collected_ff + 16'd1;

   // Next parser state and response for the incoming byte.
   always_comb begin
      phase_in        = phase_ff;
      frame_length_in = frame_length_ff;
      collected_in    = collected_ff;
      sum_in          = sum_ff;
      event_in        = frp_pkg::EV_NONE;
      pbyte_in        = '0;
      pidx_in         = '0;
      plen_in         = '0;
      if (req_ch.op == frp_pkg::OP_RESYNC) begin
         phase_in        = frp_pkg::PH_WAIT;
         frame_length_in = '0;
         collected_in    = '0;
         sum_in          = '0;
      end else begin
         unique case (phase_ff)
            frp_pkg::PH_HEAD: begin
               if (rx == frp_pkg::HEADER_1) begin
                  phase_in = frp_pkg::PH_CON;
                  sum_in   = sum_next;
               end else begin
                  phase_in        = frp_pkg::PH_WAIT;
                  frame_length_in = '0;
                  collected_in    = '0;
                  sum_in          = '0;
               end
            end
            frp_pkg::PH_CON: begin
               if (rx == expected_control_ff) begin
                  phase_in = frp_pkg::PH_CMD;
                  sum_in   = sum_next;
               end else begin
                  phase_in        = frp_pkg::PH_WAIT;
                  frame_length_in = '0;
                  collected_in    = '0;
                  sum_in          = '0;
               end
            end
            frp_pkg::PH_CMD: begin
               if (rx == expected_command_ff) begin
                  phase_in = frp_pkg::PH_LENH;
                  sum_in   = sum_next;
               end else begin
                  phase_in        = frp_pkg::PH_WAIT;
                  frame_length_in = '0;
                  collected_in    = '0;
                  sum_in          = '0;
               end
            end
            frp_pkg::PH_LENH: begin
               frame_length_in = {rx, 8'h00};
               sum_in          = sum_next;
               phase_in        = frp_pkg::PH_LENL;
            end
            frp_pkg::PH_LENL: begin
               // A zero length goes straight to the checksum byte.
               frame_length_in = length_full;
               collected_in    = '0;
               sum_in          = sum_next;
               phase_in        = (length_full == '0) ? frp_pkg::PH_CHK
                                                     : frp_pkg::PH_DATA;
            end
            frp_pkg::PH_DATA: begin
               event_in     = frp_pkg::EV_BYTE;
               pbyte_in     = rx;
               pidx_in      = collected_ff;
               plen_in      = frame_length_ff;
               sum_in       = sum_next;
               collected_in = collected_inc;
               if (collected_inc >= frame_length_ff) begin
                  phase_in = frp_pkg::PH_CHK;
               end
            end
            frp_pkg::PH_CHK: begin
               if (rx == sum_ff) begin
                  phase_in = frp_pkg::PH_ENDH;
               end else begin
                  event_in        = frp_pkg::EV_CSUM;
                  plen_in         = frame_length_ff;
                  phase_in        = frp_pkg::PH_WAIT;
                  frame_length_in = '0;
                  collected_in    = '0;
                  sum_in          = '0;
               end
            end
            frp_pkg::PH_ENDH: begin
               if (rx == frp_pkg::FOOTER_0) begin
                  phase_in = frp_pkg::PH_ENDL;
               end else begin
                  event_in        = frp_pkg::EV_FOOT;
                  plen_in         = frame_length_ff;
                  phase_in        = frp_pkg::PH_WAIT;
                  frame_length_in = '0;
                  collected_in    = '0;
                  sum_in          = '0;
               end
            end
            frp_pkg::PH_ENDL: begin
               event_in        = (rx == frp_pkg::FOOTER_1) ? frp_pkg::EV_GOOD
                                                           : frp_pkg::EV_FOOT;
               plen_in         = frame_length_ff;
               phase_in        = frp_pkg::PH_WAIT;
               frame_length_in = '0;
               collected_in    = '0;
               sum_in          = '0;
            end
            default: begin
               // Header search; unused codes behave the same way.
               frame_length_in = '0;
               collected_in    = '0;
               if (rx == frp_pkg::HEADER_0) begin
                  phase_in = frp_pkg::PH_HEAD;
                  sum_in   = rx;
               end else begin
                  phase_in = frp_pkg::PH_WAIT;
                  sum_in   = '0;
               end
            end
         endcase
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_control_ff <= '0;
         expected_command_ff <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            frp_pkg::CSR_CONTROL: expected_control_ff <= csr_ch.data;
            frp_pkg::CSR_COMMAND: expected_command_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // Parser state advances on each request transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= frp_pkg::PH_WAIT;
         frame_length_ff <= '0;
         collected_ff    <= '0;
         sum_ff          <= '0;
      end else if (req_xfer) begin
         phase_ff        <= phase_in;
         frame_length_ff <= frame_length_in;
         collected_ff    <= collected_in;
         sum_ff          <= sum_in;
      end
   end

   // Response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload loads with each request transfer.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         event_ff <= event_in;
         pbyte_ff <= pbyte_in;
         pidx_ff  <= pidx_in;
         plen_ff  <= plen_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.event_res      = event_ff;
   assign rsp_ch.payload_byte   = pbyte_ff;
   assign rsp_ch.payload_index  = pidx_ff;
   assign rsp_ch.payload_length = plen_ff;

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Framed reply parser testbench
// Drives received bytes and resync operations into the parser core and
// checks every parse event against a cycle-free shadow of the parser. A
// short directed table comes first. Random frames follow: mostly well
// formed, some corrupted, truncated or mixed with noise. Both channels idle
// at random, and the register settings change between phases.
// ----------------------------------------------------------------------------
module testbench;

   // One parse event as it leaves the response channel.
   typedef struct packed {
      frp_pkg::event_type  ev_code;
      frp_pkg::byte_type   data_byte;
      frp_pkg::length_type byte_index;
      frp_pkg::length_type frame_len;
   } parse_event_type;

   // One row of the directed table; fixed rows carry a typed-in result.
   typedef struct packed {
      frp_pkg::op_type   op;
      frp_pkg::byte_type rx;
      logic              fixed;
      parse_event_type   want;
   } stim_row_type;

   localparam int unsigned PHASE_ITEMS  = 265;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned MAX_REPORTS  = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   frp_req_if req_ch ();
   frp_rsp_if rsp_ch ();
   frp_csr_if csr_ch ();

   framed_reply_parser_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Shadow of the parser state and its registers.
   frp_pkg::phase_type  shadow_phase;
   frp_pkg::length_type shadow_len;
   frp_pkg::length_type shadow_count;
   frp_pkg::byte_type   shadow_sum;
   frp_pkg::byte_type   shadow_control;
   frp_pkg::byte_type   shadow_command;

   parse_event_type pending_events [$];
   int unsigned     items_sent  = 0;
   int unsigned     mismatches  = 0;
   int unsigned     idle_cycles = 0;
   bit              steady      = 1'b0;
   bit              hold_long   = 1'b0;
   int unsigned     stall_left  = 0;

   // Directed table, written for the reset values of both registers.
   stim_row_type directed_rows [25] = '{
      // Noise and a resync at reset.
      '{frp_pkg::OP_BYTE,   8'hFF, 1'b1, '{frp_pkg::EV_NONE, 8'h00, 16'd0, 16'd0}},
      '{frp_pkg::OP_RESYNC, 8'hAA, 1'b1, '{frp_pkg::EV_NONE, 8'h00, 16'd0, 16'd0}},
      // Good frame with a single payload byte of all ones.
      '{frp_pkg::OP_BYTE,   8'h53, 1'b0, '0},
      '{frp_pkg::OP_BYTE,   8'h59, 1'b0, '0},
      '{frp_pkg::OP_BYTE,   8'h00, 1'b0, '0},
      '{frp_pkg::OP_BYTE,   8'h00, 1'b0, '0},
      '{frp_pkg::OP_BYTE,   8'h00, 1'b0, '0},
      '{frp_pkg::OP_BYTE,   8'h01, 1'b0, '0},
      '{frp_pkg::OP_BYTE,   8'hFF, 1'b1, '{frp_pkg::EV_BYTE, 8'hFF, 16'd0, 16'd1}},
      '{frp_pkg::OP_BYTE,   8'hAC, 1'b0, '0},
      '{frp_pkg::OP_BYTE,   8'h54, 1'b0, '0},
      '{frp_pkg::OP_BYTE,   8'h43, 1'b1, '{frp_pkg::EV_GOOD, 8'h00, 16'd0, 16'd1}},
      // Zero length frame whose checksum is wrong.
      '{frp_pkg::OP_BYTE,   8'h53, 1'b0, '0},
      '{frp_pkg::OP_BYTE,   8'h59, 1'b0, '0},
      '{frp_pkg::OP_BYTE,   8'h00, 1'b0, '0},
      '{frp_pkg::OP_BYTE,   8'h00, 1'b0, '0},
      '{frp_pkg::OP_BYTE,   8'h00, 1'b0, '0},
      '{frp_pkg::OP_BYTE,   8'h00, 1'b0, '0},
      '{frp_pkg::OP_BYTE,   8'h00, 1'b1, '{frp_pkg::EV_CSUM, 8'h00, 16'd0, 16'd0}},
      // Header mismatch; the offending byte does not restart the search.
      '{frp_pkg::OP_BYTE,   8'h53, 1'b0, '0},
      '{frp_pkg::OP_BYTE,   8'h53, 1'b1, '{frp_pkg::EV_NONE, 8'h00, 16'd0, 16'd0}},
      '{frp_pkg::OP_BYTE,   8'h59, 1'b1, '{frp_pkg::EV_NONE, 8'h00, 16'd0, 16'd0}},
      // Control byte mismatch.
      '{frp_pkg::OP_BYTE,   8'h53, 1'b0, '0},
      '{frp_pkg::OP_BYTE,   8'h59, 1'b0, '0},
      '{frp_pkg::OP_BYTE,   8'h01, 1'b1, '{frp_pkg::EV_NONE, 8'h00, 16'd0, 16'd0}}
   };

   // Clock with a period of four time units.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Clear the shadow parser back to the header search.
   function automatic void clear_shadow();
      shadow_phase = frp_pkg::PH_WAIT;
      shadow_len   = '0;
      shadow_count = '0;
      shadow_sum   = '0;
   endfunction

   // Advance the shadow parser by one item and return the event it causes.
   function automatic parse_event_type next_parse_event(frp_pkg::op_type op,
                                                        frp_pkg::byte_type rx);
      parse_event_type   ev;
      frp_pkg::byte_type sum_next;
      ev       = '0;
      sum_next = shadow_sum + rx;
      if (op == frp_pkg::OP_RESYNC) begin
         clear_shadow();
      end else begin
         case (shadow_phase)
            frp_pkg::PH_HEAD: begin
               if (rx == frp_pkg::HEADER_1) begin
                  shadow_phase = frp_pkg::PH_CON;
                  shadow_sum   = sum_next;
               end else begin
                  clear_shadow();
               end
            end
            frp_pkg::PH_CON: begin
               if (rx == shadow_control) begin
                  shadow_phase = frp_pkg::PH_CMD;
                  shadow_sum   = sum_next;
               end else begin
                  clear_shadow();
               end
            end
            frp_pkg::PH_CMD: begin
               if (rx == shadow_command) begin
                  shadow_phase = frp_pkg::PH_LENH;
                  shadow_sum   = sum_next;
               end else begin
                  clear_shadow();
               end
            end
            frp_pkg::PH_LENH: begin
               shadow_len   = {rx, 8'h00};
               shadow_sum   = sum_next;
               shadow_phase = frp_pkg::PH_LENL;
            end
            frp_pkg::PH_LENL: begin
               shadow_len   = {shadow_len[15:8], rx};
               shadow_count = '0;
               shadow_sum   = sum_next;
               shadow_phase = (shadow_len == '0) ? frp_pkg::PH_CHK : frp_pkg::PH_DATA;
            end
            frp_pkg::PH_DATA: begin
               ev.ev_code    = frp_pkg::EV_BYTE;
               ev.data_byte  = rx;
               ev.byte_index = shadow_count;
               ev.frame_len  = shadow_len;
               shadow_sum    = sum_next;
               shadow_count  = shadow_count + 16'd1;
               if (shadow_count >= shadow_len) shadow_phase = frp_pkg::PH_CHK;
            end
            frp_pkg::PH_CHK: begin
               ev.frame_len = shadow_len;
               if (rx == shadow_sum) begin
                  shadow_phase = frp_pkg::PH_ENDH;
               end else begin
                  ev.ev_code = frp_pkg::EV_CSUM;
                  clear_shadow();
               end
            end
            frp_pkg::PH_ENDH: begin
               ev.frame_len = shadow_len;
               if (rx == frp_pkg::FOOTER_0) begin
                  shadow_phase = frp_pkg::PH_ENDL;
               end else begin
                  ev.ev_code = frp_pkg::EV_FOOT;
                  clear_shadow();
               end
            end
            frp_pkg::PH_ENDL: begin
               ev.frame_len = shadow_len;
               ev.ev_code   = (rx == frp_pkg::FOOTER_1) ? frp_pkg::EV_GOOD
                                                        : frp_pkg::EV_FOOT;
               clear_shadow();
            end
            default: begin
               clear_shadow();
               if (rx == frp_pkg::HEADER_0) begin
                  shadow_phase = frp_pkg::PH_HEAD;
                  shadow_sum   = rx;
               end
            end
         endcase
      end
      if (ev.ev_code == frp_pkg::EV_NONE) ev.frame_len = '0;
      return ev;
   endfunction

   // Idle gap length: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady) return 0;
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Offer one item, wait for its transfer, then record the expected event.
   task automatic send_item(frp_pkg::op_type op, frp_pkg::byte_type rx, logic fixed,
                            parse_event_type want);
      int unsigned     gap;
      parse_event_type predicted;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.op      <= op;
      req_ch.rx_byte <= rx;
      do @(posedge clock); while (!req_ch.ready);
      predicted = next_parse_event(op, rx);
      pending_events.push_back(fixed ? want : predicted);
      items_sent++;
   endtask

   task automatic send_byte(frp_pkg::byte_type rx);
      send_item(frp_pkg::OP_BYTE, rx, 1'b0, '0);
   endtask

   // Stop offering items and wait until every expected event has arrived.
   task automatic drain_events();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
   endtask

   // Write one register; only called while the parser is drained.
   task automatic write_csr(frp_pkg::csr_idx_type idx, frp_pkg::byte_type data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      if (idx == frp_pkg::CSR_CONTROL) shadow_control = data;
      else shadow_command = data;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // One random frame: well formed, corrupted, truncated, noise or a resync.
   task automatic send_frame();
      frp_pkg::byte_type   frame [$];
      frp_pkg::byte_type   sum;
      frp_pkg::length_type flen;
      int unsigned         kind;
      int unsigned         chk_pos;
      int unsigned         stop;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         repeat ($urandom_range(1, 6)) send_byte(frp_pkg::byte_type'($urandom));
      end else if (kind < 11) begin
         send_item(frp_pkg::OP_RESYNC, frp_pkg::byte_type'($urandom), 1'b0, '0);
      end else if (kind < 14) begin
         // Random length field, cut short by a resync.
         flen  = frp_pkg::length_type'($urandom);
         frame = '{frp_pkg::HEADER_0, frp_pkg::HEADER_1, shadow_control, shadow_command,
                   flen[15:8], flen[7:0]};
         repeat ($urandom_range(0, 8)) frame.push_back(frp_pkg::byte_type'($urandom));
         foreach (frame[i]) send_byte(frame[i]);
         send_item(frp_pkg::OP_RESYNC, frp_pkg::byte_type'($urandom), 1'b0, '0);
      end else begin
         if ($urandom_range(0, 19) == 0)
            flen = frp_pkg::length_type'($urandom_range(64, 300));
         else
            flen = frp_pkg::length_type'($urandom_range(0, 12));
         frame = '{frp_pkg::HEADER_0, frp_pkg::HEADER_1, shadow_control, shadow_command,
                   flen[15:8], flen[7:0]};
         repeat (flen) frame.push_back(frp_pkg::byte_type'($urandom));
         sum = '0;
         foreach (frame[i]) sum = sum + frame[i];
         chk_pos = frame.size();
         frame.push_back(sum);
         frame.push_back(frp_pkg::FOOTER_0);
         frame.push_back(frp_pkg::FOOTER_1);
         stop = frame.size();
         // Corrupt one field of the frame, or cut it short.
         if (kind < 18) frame[1] = frame[1] ^ frp_pkg::byte_type'($urandom_range(1, 255));
         else if (kind < 22)
            frame[2] = frame[2] ^ frp_pkg::byte_type'($urandom_range(1, 255));
         else if (kind < 26)
            frame[3] = frame[3] ^ frp_pkg::byte_type'($urandom_range(1, 255));
         else if (kind < 32)
            frame[chk_pos] = frame[chk_pos] ^ frp_pkg::byte_type'($urandom_range(1, 255));
         else if (kind < 37)
            frame[chk_pos+1] = frame[chk_pos+1] ^ frp_pkg::byte_type'($urandom_range(1, 255));
         else if (kind < 42)
            frame[chk_pos+2] = frame[chk_pos+2] ^ frp_pkg::byte_type'($urandom_range(1, 255));
         else if (kind < 47) stop = $urandom_range(1, frame.size() - 1);
         for (int unsigned i = 0; i < stop; i++) send_byte(frame[i]);
         if (stop < frame.size())
            send_item(frp_pkg::OP_RESYNC, frp_pkg::byte_type'($urandom), 1'b0, '0);
      end
   endtask

   // Response ready: random stalls, plus one long hold-off on request.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_long) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_long = 1'b0;
            rsp_ch.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) stall_left = pick_gap();
         end
      end
   end

   // Compare each response transfer with the oldest expected event.
   always @(posedge clock) begin
      parse_event_type got;
      parse_event_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.event_res, rsp_ch.payload_byte, rsp_ch.payload_index,
                    rsp_ch.payload_length};
            if (pending_events.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected event %0d byte %h index %0d length %0d",
                           got.ev_code, got.data_byte, got.byte_index, got.frame_len);
            end else begin
               want = pending_events.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("mismatch: expected ev %0d byte %h index %0d length %0d, %s",
                              want.ev_code, want.data_byte, want.byte_index,
                              want.frame_len, $sformatf("got ev %0d byte %h index %0d length %0d",
                              got.ev_code, got.data_byte, got.byte_index, got.frame_len));
               end
            end
         end
         // Watchdog on cycles without any transfer.
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   // Stimulus: reset, directed table, then random phases.
   initial begin
      req_ch.valid   = 1'b0;
      req_ch.op      = frp_pkg::OP_BYTE;
      req_ch.rx_byte = '0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = frp_pkg::CSR_CONTROL;
      csr_ch.data    = '0;
      shadow_control = '0;
      shadow_command = '0;
      clear_shadow();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].op, directed_rows[i].rx, directed_rows[i].fixed,
                   directed_rows[i].want);

      for (int p = 0; p < 5; p++) begin
         int unsigned goal;
         // Register changes only once the parser has drained.
         drain_events();
         case (p)
            0: begin
               write_csr(frp_pkg::CSR_CONTROL, 8'hFF);
               write_csr(frp_pkg::CSR_COMMAND, 8'hFF);
            end
            1: begin
               write_csr(frp_pkg::CSR_CONTROL, 8'h00);
               write_csr(frp_pkg::CSR_COMMAND, 8'hFF);
               hold_long = 1'b1;
            end
            2: begin
               write_csr(frp_pkg::CSR_CONTROL, 8'hFF);
               write_csr(frp_pkg::CSR_COMMAND, 8'h00);
            end
            default: begin
               write_csr(frp_pkg::CSR_CONTROL, frp_pkg::byte_type'($urandom));
               write_csr(frp_pkg::CSR_COMMAND, frp_pkg::byte_type'($urandom));
            end
         endcase
         steady = (p == 3);
         goal   = items_sent + PHASE_ITEMS;
         while (items_sent < goal) send_frame();
      end

      drain_events();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_events.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
